[hdl/priority_voice_allocator_macros.svh]
// Assertion macros shared by the voice allocator RTL.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef PRIORITY_VOICE_ALLOCATOR_MACROS_SVH
`define PRIORITY_VOICE_ALLOCATOR_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PVA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define PVA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pva_pkg.sv]
// Shared types and constants of the priority voice allocator.
// No dependencies; imported by every RTL file of the block.
package pva_pkg;

    localparam int unsigned NUM_VOICES_DEF    = 32;
    localparam int unsigned NUM_SOUND_IDS_DEF = 64;
    localparam int unsigned PRIORITY_BITS_DEF = 8;

    localparam logic OP_PLAY = 1'b0;
    localparam logic OP_STOP = 1'b1;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_LIMIT   = 3'd1,
        ST_LOWPRIO = 3'd2,
        ST_STOPPED = 3'd3,
        ST_IDLE    = 3'd4
    } t_status;

    typedef struct packed {
        logic       operation;
        logic [5:0] sound_id;
        logic [7:0] priority_req;
        logic [5:0] max_playbacks;
        logic [4:0] voice;
    } t_pva_in;

    typedef struct packed {
        t_status    status;
        logic [4:0] granted_voice;
        logic       stole;
        logic [4:0] stolen_voice;
        logic [5:0] active_count;
    } t_pva_out;

endpackage

[hdl/pva_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Uses pva_pkg for the default depth, NUM_VOICES_DEF.
module pva_ram
    import pva_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = NUM_VOICES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/priority_voice_allocator.sv]
// Priority voice allocator top level. One beat is in work at a time: the input stalls
// from acceptance until the result is handed to the output register, and the work per
// beat is set by the walk over the active-list memory (one entry a cycle); a stalled
// output beat holds the result and keeps the next beat waiting.
// Synchronous active-low reset, then a clearing pass over max(NUM_VOICES, NUM_SOUND_IDS)
// entries fills the free stack and zeroes the use counts; input stalls until it ends.
`include "priority_voice_allocator_macros.svh"

module priority_voice_allocator
    import pva_pkg::*;
#(
    parameter int unsigned NUM_VOICES    = NUM_VOICES_DEF,
    parameter int unsigned NUM_SOUND_IDS = NUM_SOUND_IDS_DEF,
    parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_pva_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_pva_out o_out
);

    // Widths: voice index, counts up to NUM_VOICES, sound index, list entry.
    localparam int unsigned VW     = $clog2(NUM_VOICES);
    localparam int unsigned CW     = $clog2(NUM_VOICES + 1);
    localparam int unsigned SW     = (NUM_SOUND_IDS > 1) ? $clog2(NUM_SOUND_IDS) : 1;
    localparam int unsigned PB     = PRIORITY_BITS;
    localparam int unsigned EW     = VW + PB + SW;
    localparam int unsigned INIT_N = (NUM_VOICES > NUM_SOUND_IDS) ? NUM_VOICES
                                                                   : NUM_SOUND_IDS;
    localparam int unsigned IW     = $clog2(INIT_N + 1);

    // One slot of the active list, kept in rising priority order.
    typedef struct packed {
        logic [VW-1:0] voice;
        logic [PB-1:0] prio;
        logic [SW-1:0] snd;
    } t_entry;

    typedef enum logic [3:0] {
        S_INIT,   // clearing pass after reset
        S_IDLE,   // wait for a request beat
        S_PCHK,   // compare sound use count against the limit
        S_SLOW,   // all busy: inspect the lowest-priority voice
        S_SWALK,  // steal: shift lower entries down, find the slot
        S_POP,    // take a voice from the free stack
        S_IWALK,  // insert: shift higher entries up, find the slot
        S_INS,    // write the new entry
        S_RWALK,  // stop: find the voice, close the gap
        S_URD,    // read a use count
        S_UWR,    // write it back adjusted
        S_DONE    // hand the result to the output register
    } t_state;

    t_state               r_state, n_state;
    logic [IW-1:0]        r_init_idx, n_init_idx;
    logic [NUM_VOICES-1:0] r_active, n_active;
    logic [CW-1:0]        r_pc, n_pc;          // playing voices
    logic [CW-1:0]        r_fc, n_fc;          // free stack depth
    logic                 r_op, n_op;
    logic [5:0]           r_snd, n_snd;
    logic [PB-1:0]        r_prio, n_prio;
    logic [5:0]           r_limit, n_limit;
    logic [VW-1:0]        r_voice, n_voice;
    logic [CW-1:0]        r_idx, n_idx;
    logic [VW-1:0]        r_pos, n_pos;
    logic                 r_found, n_found;
    logic [VW-1:0]        r_new_voice, n_new_voice;
    logic [SW-1:0]        r_old_snd, n_old_snd;
    logic                 r_stole, n_stole;
    t_status              r_status, n_status;
    logic [SW-1:0]        r_use_addr, n_use_addr;
    logic                 r_use_inc, n_use_inc;
    logic                 r_out_valid, n_out_valid;
    t_pva_out             r_out, n_out;

    // Memory ports.
    logic          w_list_we;
    logic [VW-1:0] w_list_waddr, w_list_raddr;
    t_entry        w_list_wdata, w_entry;
    logic [EW-1:0] w_list_rdata;
    logic          w_free_we;
    logic [VW-1:0] w_free_waddr, w_free_raddr, w_free_rdata, w_free_wdata;
    logic          w_use_we;
    logic [SW-1:0] w_use_waddr, w_use_raddr;
    logic [CW-1:0] w_use_wdata, w_use_rdata;

    logic            w_accept;
    logic [PB+7:0]   w_prio_ext;
    logic [PB-1:0]   w_prio_in;
    logic [VW-1:0]   w_vidx;
    logic            w_vreq_ok;
    logic            w_snd_ok;
    logic [SW-1:0]   w_snd_fnd;

    // Active list: one entry per playing voice, lowest priority at index 0.
    pva_ram #(.WIDTH(EW), .DEPTH(NUM_VOICES)) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (w_list_we),
        .i_waddr (w_list_waddr),
        .i_wdata (w_list_wdata),
        .i_raddr (w_list_raddr),
        .o_rdata (w_list_rdata)
    );

    // LIFO of idle voices; top is entry r_fc - 1.
    pva_ram #(.WIDTH(VW), .DEPTH(NUM_VOICES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_free_we),
        .i_waddr (w_free_waddr),
        .i_wdata (w_free_wdata),
        .i_raddr (w_free_raddr),
        .o_rdata (w_free_rdata)
    );

    // Voices held by each sound.
    pva_ram #(.WIDTH(CW), .DEPTH(NUM_SOUND_IDS)) u_use_ram (
        .i_clk   (i_clk),
        .i_we    (w_use_we),
        .i_waddr (w_use_waddr),
        .i_wdata (w_use_wdata),
        .i_raddr (w_use_raddr),
        .o_rdata (w_use_rdata)
    );

    assign w_entry    = w_list_rdata;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Take the request priority in its low PRIORITY_BITS bits.
    assign w_prio_ext = {PB'(0), i_in.priority_req};
    assign w_prio_in  = w_prio_ext[PB-1:0];
    assign w_vidx     = VW'(i_in.voice);
    assign w_vreq_ok  = (32'(i_in.voice) < NUM_VOICES);
    assign w_snd_ok   = (32'(i_in.sound_id) < NUM_SOUND_IDS);
    assign w_snd_fnd  = r_found ? r_old_snd : w_entry.snd;

    always_comb begin
        n_state     = r_state;
        n_init_idx  = r_init_idx;
        n_active    = r_active;
        n_pc        = r_pc;
        n_fc        = r_fc;
        n_op        = r_op;
        n_snd       = r_snd;
        n_prio      = r_prio;
        n_limit     = r_limit;
        n_voice     = r_voice;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_found     = r_found;
        n_new_voice = r_new_voice;
        n_old_snd   = r_old_snd;
        n_stole     = r_stole;
        n_status    = r_status;
        n_use_addr  = r_use_addr;
        n_use_inc   = r_use_inc;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        w_list_we    = 1'b0;
        w_list_waddr = '0;
        w_list_wdata = w_entry;
        w_list_raddr = '0;
        w_free_we    = 1'b0;
        w_free_waddr = '0;
        w_free_wdata = r_voice;
        w_free_raddr = '0;
        w_use_we     = 1'b0;
        w_use_waddr  = r_use_addr;
        w_use_wdata  = '0;
        w_use_raddr  = r_use_addr;

        // Drop the output beat once taken.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                // Free stack holds voice 0 on top; use counts start at zero.
                w_free_we    = (32'(r_init_idx) < NUM_VOICES);
                w_free_waddr = VW'(r_init_idx);
                w_free_wdata = VW'(NUM_VOICES - 1 - 32'(r_init_idx));
                w_use_we     = (32'(r_init_idx) < NUM_SOUND_IDS);
                w_use_waddr  = SW'(r_init_idx);
                w_use_wdata  = '0;
                n_init_idx   = r_init_idx + IW'(1);
                if (32'(r_init_idx) == INIT_N - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op      = i_in.operation;
                    n_snd     = i_in.sound_id;
                    n_prio    = w_prio_in;
                    n_limit   = i_in.max_playbacks;
                    n_voice   = w_vidx;
                    n_stole   = 1'b0;
                    n_found   = 1'b0;
                    n_idx     = '0;
                    if (i_in.operation == OP_STOP) begin
                        if (w_vreq_ok && r_active[w_vidx]) begin
                            w_list_raddr = '0;
                            n_state      = S_RWALK;
                        end else begin
                            n_status = ST_IDLE;
                            n_state  = S_DONE;
                        end
                    end else if (!w_snd_ok) begin
                        n_status = ST_LIMIT;
                        n_state  = S_DONE;
                    end else begin
                        w_use_raddr = SW'(i_in.sound_id);
                        n_state     = S_PCHK;
                    end
                end
            end
            S_PCHK: begin
                if (32'(w_use_rdata) >= 32'(r_limit)) begin
                    n_status = ST_LIMIT;
                    n_state  = S_DONE;
                end else if (r_pc == CW'(NUM_VOICES)) begin
                    w_list_raddr = '0;
                    n_state      = S_SLOW;
                end else begin
                    w_free_raddr = VW'(r_fc - CW'(1));
                    n_state      = S_POP;
                end
            end
            S_SLOW: begin
                if (r_prio < w_entry.prio) begin
                    n_status = ST_LOWPRIO;
                    n_state  = S_DONE;
                end else begin
                    // The stolen voice is reused directly; the free stack is not touched.
                    n_stole      = 1'b1;
                    n_new_voice  = w_entry.voice;
                    n_old_snd    = w_entry.snd;
                    n_idx        = CW'(1);
                    w_list_raddr = VW'(1);
                    n_state      = S_SWALK;
                end
            end
            S_SWALK: begin
                if (w_entry.prio < r_prio) begin
                    w_list_we    = 1'b1;
                    w_list_waddr = VW'(r_idx - CW'(1));
                    w_list_wdata = w_entry;
                    if ((r_idx + CW'(1)) == r_pc) begin
                        n_pos   = VW'(r_idx);
                        n_state = S_INS;
                    end else begin
                        n_idx        = r_idx + CW'(1);
                        w_list_raddr = VW'(r_idx + CW'(1));
                    end
                end else begin
                    n_pos   = VW'(r_idx - CW'(1));
                    n_state = S_INS;
                end
            end
            S_POP: begin
                n_new_voice = w_free_rdata;
                if (r_pc == '0) begin
                    n_pos   = '0;
                    n_state = S_INS;
                end else begin
                    n_idx        = r_pc - CW'(1);
                    w_list_raddr = VW'(r_pc - CW'(1));
                    n_state      = S_IWALK;
                end
            end
            S_IWALK: begin
                // New voice lands below the first entry of equal or greater priority.
                if (w_entry.prio >= r_prio) begin
                    w_list_we    = 1'b1;
                    w_list_waddr = VW'(r_idx + CW'(1));
                    w_list_wdata = w_entry;
                    if (r_idx == '0) begin
                        n_pos   = '0;
                        n_state = S_INS;
                    end else begin
                        n_idx        = r_idx - CW'(1);
                        w_list_raddr = VW'(r_idx - CW'(1));
                    end
                end else begin
                    n_pos   = VW'(r_idx + CW'(1));
                    n_state = S_INS;
                end
            end
            S_INS: begin
                w_list_we          = 1'b1;
                w_list_waddr       = r_pos;
                w_list_wdata.voice = r_new_voice;
                w_list_wdata.prio  = r_prio;
                w_list_wdata.snd   = SW'(r_snd);
                n_active[r_new_voice] = 1'b1;
                n_status = ST_GRANTED;
                if (r_stole) begin
                    n_use_addr = r_old_snd;
                    n_use_inc  = 1'b0;
                end else begin
                    // Retire the popped stack entry together with the new playing voice.
                    n_pc       = r_pc + CW'(1);
                    n_fc       = r_fc - CW'(1);
                    n_use_addr = SW'(r_snd);
                    n_use_inc  = 1'b1;
                end
                n_state = S_URD;
            end
            S_RWALK: begin
                if (r_found) begin
                    w_list_we    = 1'b1;
                    w_list_waddr = VW'(r_idx - CW'(1));
                    w_list_wdata = w_entry;
                end else if (w_entry.voice == r_voice) begin
                    n_found   = 1'b1;
                    n_old_snd = w_entry.snd;
                end
                if ((r_idx + CW'(1)) == r_pc) begin
                    n_pc              = r_pc - CW'(1);
                    n_active[r_voice] = 1'b0;
                    w_free_we         = 1'b1;
                    w_free_waddr      = VW'(r_fc);
                    w_free_wdata      = r_voice;
                    n_fc              = r_fc + CW'(1);
                    n_status          = ST_STOPPED;
                    n_use_addr        = w_snd_fnd;
                    n_use_inc         = 1'b0;
                    n_state           = S_URD;
                end else begin
                    n_idx        = r_idx + CW'(1);
                    w_list_raddr = VW'(r_idx + CW'(1));
                end
            end
            S_URD: begin
                w_use_raddr = r_use_addr;
                n_state     = S_UWR;
            end
            S_UWR: begin
                w_use_waddr = r_use_addr;
                if (r_use_inc) begin
                    w_use_we    = 1'b1;
                    w_use_wdata = w_use_rdata + CW'(1);
                end else begin
                    w_use_we    = (w_use_rdata != '0);
                    w_use_wdata = w_use_rdata - CW'(1);
                end
                // After releasing a stolen voice, count the new sound.
                if (!r_use_inc && r_op == OP_PLAY) begin
                    n_use_addr = SW'(r_snd);
                    n_use_inc  = 1'b1;
                    n_state    = S_URD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status        = r_status;
                    n_out.granted_voice = (r_status == ST_GRANTED) ? 5'(r_new_voice) : '0;
                    n_out.stole         = r_stole && (r_status == ST_GRANTED);
                    n_out.stolen_voice  = (r_stole && r_status == ST_GRANTED)
                                          ? 5'(r_new_voice) : '0;
                    n_out.active_count  = 6'(r_pc);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_idx  <= '0;
            r_active    <= '0;
            r_pc        <= '0;
            r_fc        <= CW'(NUM_VOICES);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_idx  <= n_init_idx;
            r_active    <= n_active;
            r_pc        <= n_pc;
            r_fc        <= n_fc;
            r_out_valid <= n_out_valid;
        end
        r_op        <= n_op;
        r_snd       <= n_snd;
        r_prio      <= n_prio;
        r_limit     <= n_limit;
        r_voice     <= n_voice;
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_found     <= n_found;
        r_new_voice <= n_new_voice;
        r_old_snd   <= n_old_snd;
        r_stole     <= n_stole;
        r_status    <= n_status;
        r_use_addr  <= n_use_addr;
        r_use_inc   <= n_use_inc;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Every voice is either on the free stack or in the active list.
    `PVA_ASSERT_ALWAYS(a_voice_total, (32'(r_pc) + 32'(r_fc)) == NUM_VOICES, "voice count lost")
    `PVA_ASSERT_ALWAYS(a_active_bits, $countones(r_active) == int'(r_pc), "active bits mismatch")
    `PVA_ASSERT_IMPL(a_steal_reuse, o_out_valid && o_out.stole, (o_out.status == ST_GRANTED) && (o_out.stolen_voice == o_out.granted_voice), "stolen voice not reused")
    `PVA_ASSERT_NEXT(a_busy_after_accept, w_accept, o_in_stall, "accepted while busy")

endmodule
